@@ hw/rtl/lruc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lruc_pkg;
	localparam int ENTRIES_DEF = 32;
	localparam logic [31:0] TTL_RESET = 32'd300000;
	localparam logic [5:0] CAPACITY_RESET = 6'd32;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSTALL = 2'd1;
	localparam logic [1:0] REQ_SHUTDOWN = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [2:0] ST_HIT = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_NO_COMPILER = 3'd2;
	localparam logic [2:0] ST_COMPILE_FAILED = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	localparam logic CFG_TTL = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXPIRE,
		S_MATCH,
		S_UPDATE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic expire;
		logic match;
		logic update;
	} cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/lruc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lruc_ctrl import lruc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] req_type,
	output logic out_valid,
	input wire logic out_ready,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type != REQ_LOOKUP) begin
						cmd.clear = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_EXPIRE;
					end
				end
			end
			S_EXPIRE: begin
				cmd.expire = 1'b1;
				state_d = S_MATCH;
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/lruc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lruc_dp import lruc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_take,
	input wire logic [1:0] req_type,
	input wire logic [63:0] key_word_0,
	input wire logic [63:0] key_word_1,
	input wire logic [63:0] key_word_2,
	input wire logic [63:0] key_word_3,
	input wire logic [63:0] now_ms,
	input wire logic compile_ok,
	input wire logic [31:0] ttl,
	input wire logic [5:0] capacity,
	input wire cmd_t cmd,
	output logic [2:0] status,
	output logic [5:0] expired_count,
	output logic [5:0] evicted_count,
	output logic [5:0] entry_count
);
	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [255:0] key_q [ENTRIES];
	logic [63:0] time_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [RW-1:0] rank_q [ENTRIES];
	logic [CW-1:0] held_q;
	logic compiler_q;

	logic [255:0] key_s1;
	logic [63:0] now_s1;
	logic ok_s1;
	logic hit_q;
	logic [RW-1:0] hrank_q;
	logic [RW-1:0] hidx_q;
	logic [CW-1:0] exp_q;

	logic [ENTRIES-1:0] expv;
	logic [ENTRIES-1:0] hitv;
	logic [CW-1:0] exp_n;
	logic [RW-1:0] hidx;
	logic [CW:0] cap_w;
	logic [ENTRIES-1:0] evv;
	logic [ENTRIES-1:0] remv;
	logic [CW-1:0] ev_n;
	logic [CW-1:0] rem_n;
	logic [RW-1:0] slot;

	always_comb begin
		exp_n = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			expv[i] = valid_q[i] && (ttl != 32'd0) && (now_s1 >= time_q[i]) &&
				((now_s1 - time_q[i]) >= {32'd0, ttl});
			exp_n = exp_n + CW'(expv[i]);
		end
	end

	// first matching slot
	always_comb begin
		hidx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hitv[i] = valid_q[i] && (key_q[i] == key_s1);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hitv[i]) hidx = RW'(i);
		end
	end

	// insert: ranks are dense after expiry compaction
	always_comb begin
		if (capacity == 6'd0) cap_w = (CW+1)'(1);
		else if ({{(CW+1 > 6 ? CW+1-6 : 0){1'b0}}, capacity} > (CW+1)'(ENTRIES))
			cap_w = (CW+1)'(ENTRIES);
		else cap_w = (CW+1)'(capacity);
		ev_n = '0;
		rem_n = '0;
		slot = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			evv[i] = valid_q[i] && (({1'b0, rank_q[i]} + 1'b1) >= cap_w[RW:0]) &&
				(cap_w <= (CW+1)'(ENTRIES));
			ev_n = ev_n + CW'(evv[i]);
			remv[i] = valid_q[i] && !evv[i];
			rem_n = rem_n + CW'(remv[i]);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!remv[i]) slot = RW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			held_q <= '0;
			compiler_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
			held_q <= '0;
			compiler_q <= (req_type == REQ_INSTALL);
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.expire) begin
			valid_q <= valid_q & ~expv;
			held_q <= held_q - exp_n;
			for (int i = 0; i < ENTRIES; i++) begin
				automatic logic [RW-1:0] d = '0;
				for (int j = 0; j < ENTRIES; j++)
					if (expv[j] && rank_q[j] < rank_q[i]) d = d + 1'b1;
				rank_q[i] <= rank_q[i] - d;
			end
		end else if (cmd.update) begin
			if (hit_q) begin
				for (int i = 0; i < ENTRIES; i++)
					if (valid_q[i] && rank_q[i] < hrank_q) rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[hidx_q] <= '0;
				time_q[hidx_q] <= now_s1;
			end else if (compiler_q && ok_s1) begin
				valid_q <= remv | (ENTRIES'(1) << slot);
				held_q <= rem_n + 1'b1;
				for (int i = 0; i < ENTRIES; i++)
					if (remv[i]) rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[slot] <= '0;
				key_q[slot] <= key_s1;
				time_q[slot] <= now_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			key_s1 <= {key_word_3, key_word_2, key_word_1, key_word_0};
			now_s1 <= now_ms;
			ok_s1 <= compile_ok;
			exp_q <= '0;
			status <= ST_CLEARED;
			expired_count <= '0;
			evicted_count <= '0;
			entry_count <= '0;
		end
		if (cmd.expire) exp_q <= exp_n;
		if (cmd.match) begin
			hit_q <= |hitv;
			hidx_q <= hidx;
			hrank_q <= rank_q[hidx];
		end
		if (cmd.update) begin
			expired_count <= 6'(exp_q);
			if (hit_q) begin
				status <= ST_HIT;
				evicted_count <= '0;
				entry_count <= 6'(held_q);
			end else if (!compiler_q) begin
				status <= ST_NO_COMPILER;
				evicted_count <= '0;
				entry_count <= 6'(held_q);
			end else if (!ok_s1) begin
				status <= ST_COMPILE_FAILED;
				evicted_count <= '0;
				entry_count <= 6'(held_q);
			end else begin
				status <= ST_INSERTED;
				evicted_count <= 6'(ev_n);
				entry_count <= 6'(rem_n + 1'b1);
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/lru_cache_with_ttl_expiry_core.sv @@
// Lookup cache of 256-bit keys, most-recent-first, with idle-time expiry.
// A lookup's result is valid once the sequencer has stepped through the
// expiry sweep, parallel key compare and rank update states in turn; a clear
// request's result is valid the cycle after acceptance. The result then waits
// for out_ready, and the next request is taken the cycle after the result
// leaves. One request is in flight at a time, set by the sequencer in
// lruc_ctrl. Issue configuration writes only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module lru_cache_with_ttl_expiry_core import lruc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] req_type,
	input wire logic [63:0] key_word_0,
	input wire logic [63:0] key_word_1,
	input wire logic [63:0] key_word_2,
	input wire logic [63:0] key_word_3,
	input wire logic [63:0] now_ms,
	input wire logic compile_ok,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [5:0] expired_count,
	output logic [5:0] evicted_count,
	output logic [5:0] entry_count,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);
	cmd_t cmd;
	logic [31:0] ttl_q;
	logic [5:0] capacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TTL) ttl_q <= cfg_data;
			else capacity_q <= cfg_data[5:0];
		end
	end

	lruc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	lruc_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_take(in_valid && in_ready),
		.req_type(req_type), .key_word_0(key_word_0), .key_word_1(key_word_1),
		.key_word_2(key_word_2), .key_word_3(key_word_3), .now_ms(now_ms),
		.compile_ok(compile_ok), .ttl(ttl_q), .capacity(capacity_q), .cmd(cmd),
		.status(status), .expired_count(expired_count),
		.evicted_count(evicted_count), .entry_count(entry_count)
	);
endmodule
`default_nettype wire

@@ hw/rtl/lruc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lruc_chk import lruc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [2:0] status,
	input wire logic [5:0] evicted_count,
	input wire logic [5:0] entry_count
);
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CLEARED |-> entry_count == 6'd0 && evicted_count == 6'd0)
		else $error("clear result not empty");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_CLEARED) else $error("bad status");
endmodule

bind lru_cache_with_ttl_expiry_core lruc_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.evicted_count(evicted_count), .entry_count(entry_count)
);
`default_nettype wire
